>>> rtl/core/iff_pkg.sv
// Shared types, constants and helper functions for the integer field formatter.
// Used by every module of the block; depends on nothing.
package iff_pkg;

  localparam int MAX_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int DIG_W         = 80;  // 20 BCD digits or a raw 64-bit operand
  localparam int NDIG_W        = 6;   // digit count, up to 32
  localparam int DIDX_W        = 5;   // digit index, 0 to 31
  localparam int CHAR_W        = 8;
  localparam int FW_W          = 7;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEXL = 3'd2,
    KIND_HEXU = 3'd3,
    KIND_OCT  = 3'd4,
    KIND_BIN  = 3'd5,
    KIND_PTR  = 3'd6
  } kind_e;

  // The one kind code that carries no conversion
  localparam logic [2:0] KIND_NONE = 3'd7;

  // Bits per digit in the digit word
  localparam logic [2:0] DSHIFT_BIN = 3'd1;
  localparam logic [2:0] DSHIFT_OCT = 3'd3;
  localparam logic [2:0] DSHIFT_NIB = 3'd4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

  localparam logic [127:0] DIGITS_LO = "0123456789abcdef";
  localparam logic [127:0] DIGITS_UP = "0123456789ABCDEF";

  typedef enum logic [1:0] {
    PAD_LEFT  = 2'd0,
    PAD_ZERO  = 2'd1,
    PAD_RIGHT = 2'd2
  } pad_mode_e;

  // One classified request, ready to be written out
  typedef struct packed {
    logic [DIG_W-1:0]  dw;
    logic [2:0]        dshift;
    logic              upper;
    logic [15:0]       pre;     // first prefix character in the top byte
    logic [1:0]        npre;
    logic [NDIG_W-1:0] ndig;
    logic [FW_W-1:0]   pad;
    pad_mode_e         mode;
  } desc_t;

  function automatic logic [3:0] digit_at(input logic [DIG_W-1:0] dw,
                                          input logic [2:0]       dshift,
                                          input logic [DIDX_W-1:0] idx);
    logic [6:0]       pos;
    logic [DIG_W-1:0] sh;
    logic [3:0]       mask;
    pos  = {2'b00, idx} * {4'b0000, dshift};
    sh   = dw >> pos;
    mask = (dshift == DSHIFT_BIN) ? 4'h1 :
           (dshift == DSHIFT_OCT) ? 4'h7 : 4'hf;
    return sh[3:0] & mask;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                   input logic       upper);
    logic [127:0] tab;
    logic [6:0]   base;
    tab  = upper ? DIGITS_UP : DIGITS_LO;
    base = {~d, 3'b000};  // character d sits (15 - d) bytes up
    return tab[base +: CHAR_W];
  endfunction

endpackage

>>> rtl/core/iff_front.sv
// Front end: accepts a request, forms the digit word (double dabble for decimal),
// finds the digit count and writes a descriptor into the queue. Uses iff_pkg.
module iff_front import iff_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      in_kind,
  input  logic [63:0]     in_value,
  input  logic            in_wide,
  input  logic            in_left_justify,
  input  logic            in_zero_pad,
  input  logic            in_plus_sign,
  input  logic            in_space_sign,
  input  logic            in_alternate_form,
  input  logic [FW_W-1:0] in_field_width,
  output logic            q_push,
  output desc_t           q_desc,
  input  logic            q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_CONV = 4'b0010,
    F_SCAN = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [DIG_W-1:0]  dw_r;
  logic [63:0]       bin_r;
  logic [6:0]        step_r;
  logic [2:0]        dshift_r;
  logic              upper_r;
  logic [15:0]       pre_r;
  logic [1:0]        npre_r;
  pad_mode_e         mode_r;
  logic [FW_W-1:0]   wsat_r;
  logic [DIDX_W-1:0] idx_r;

  // Request decode
  logic              accept;
  logic              kind_ok;
  logic              is_dec;
  logic [63:0]       src;
  logic [63:0]       sdec_v;
  logic              neg;
  logic [2:0]        dshift;
  logic              upper;
  logic [15:0]       pre;
  logic [1:0]        npre;
  logic [DIDX_W-1:0] maxidx;
  pad_mode_e         mode;
  logic [FW_W-1:0]   wsat;

  // Double dabble and scan
  logic [DIG_W-1:0]  adj;
  logic [3:0]        cur_digit;
  logic [NDIG_W-1:0] ndig;
  logic [FW_W-1:0]   total;

  assign accept = start && (state_r == F_IDLE);
  assign busy   = (state_r != F_IDLE);

  always_comb begin
    sdec_v  = in_wide ? in_value : {{32{in_value[31]}}, in_value[31:0]};
    neg     = in_wide ? in_value[63] : in_value[31];
    kind_ok = 1'b1;
    is_dec  = 1'b0;
    src     = in_wide ? in_value : {32'd0, in_value[31:0]};
    dshift  = DSHIFT_NIB;
    upper   = 1'b0;
    pre     = 16'd0;
    npre    = 2'd0;
    maxidx  = in_wide ? 5'd15 : 5'd7;
    unique case (in_kind) inside
      KIND_SDEC: begin
        is_dec = 1'b1;
        src    = neg ? (64'd0 - sdec_v) : sdec_v;
        maxidx = in_wide ? 5'd19 : 5'd9;
        if (neg) begin
          pre  = {CH_MINUS, 8'h00};
          npre = 2'd1;
        end else if (in_plus_sign) begin
          pre  = {CH_PLUS, 8'h00};
          npre = 2'd1;
        end else if (in_space_sign) begin
          pre  = {CH_SPACE, 8'h00};
          npre = 2'd1;
        end
      end
      KIND_UDEC: begin
        is_dec = 1'b1;
        maxidx = in_wide ? 5'd19 : 5'd9;
      end
      KIND_HEXL, KIND_HEXU: begin
        upper = (in_kind == KIND_HEXU);
        if (in_alternate_form && (src != 64'd0)) begin
          pre  = {CH_ZERO, upper ? CH_X_UP : CH_X_LO};
          npre = 2'd2;
        end
      end
      KIND_OCT: begin
        src    = {32'd0, in_value[31:0]};
        dshift = DSHIFT_OCT;
        maxidx = 5'd10;
        if (in_alternate_form && (in_value[31:0] != 32'd0)) begin
          pre  = {CH_ZERO, 8'h00};
          npre = 2'd1;
        end
      end
      KIND_BIN: begin
        src    = {32'd0, in_value[31:0]};
        dshift = DSHIFT_BIN;
        maxidx = 5'd31;
      end
      KIND_PTR: begin
        src    = in_value;
        maxidx = 5'd15;
        pre    = {CH_ZERO, CH_X_LO};
        npre   = 2'd2;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
    if (in_left_justify) begin
      mode = PAD_RIGHT;
    end else if (in_zero_pad) begin
      mode = PAD_ZERO;
    end else begin
      mode = PAD_LEFT;
    end
    wsat = (in_field_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : in_field_width;
  end

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIG_W / 4; i++) begin
      adj[4*i +: 4] = (dw_r[4*i +: 4] >= 4'd5) ? (dw_r[4*i +: 4] + 4'd3) : dw_r[4*i +: 4];
    end
  end

  assign cur_digit = digit_at(dw_r, dshift_r, idx_r);
  assign ndig      = {1'b0, idx_r} + NDIG_W'(1);
  assign total     = {5'd0, npre_r} + {1'b0, ndig};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && kind_ok) begin
          state_nxt = is_dec ? F_CONV : F_SCAN;
        end
      end
      F_CONV: begin
        if (step_r == 7'd1) begin
          state_nxt = F_SCAN;
        end
      end
      F_SCAN: begin
        if (!((idx_r != '0) && (cur_digit == 4'd0))) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind_ok) begin
      dshift_r <= dshift;
      upper_r  <= upper;
      pre_r    <= pre;
      npre_r   <= npre;
      mode_r   <= mode;
      wsat_r   <= wsat;
      idx_r    <= maxidx;
      if (is_dec) begin
        dw_r   <= '0;
        bin_r  <= in_wide ? src : {src[31:0], 32'd0};
        step_r <= in_wide ? 7'd64 : 7'd32;
      end else begin
        dw_r   <= {16'd0, src};
        bin_r  <= src;
        step_r <= 7'd0;
      end
    end else if (state_r == F_CONV) begin
      dw_r   <= {adj[DIG_W-2:0], bin_r[63]};
      bin_r  <= {bin_r[62:0], 1'b0};
      step_r <= step_r - 7'd1;
    end else if ((state_r == F_SCAN) && (idx_r != '0) && (cur_digit == 4'd0)) begin
      idx_r <= idx_r - DIDX_W'(1);
    end
  end

  assign q_push        = (state_r == F_PUSH) && !q_full;
  assign q_desc.dw     = dw_r;
  assign q_desc.dshift = dshift_r;
  assign q_desc.upper  = upper_r;
  assign q_desc.pre    = pre_r;
  assign q_desc.npre   = npre_r;
  assign q_desc.ndig   = ndig;
  assign q_desc.pad    = (wsat_r > total) ? (wsat_r - total) : '0;
  assign q_desc.mode   = mode_r;

endmodule

>>> rtl/core/iff_queue.sv
// Short descriptor queue between the front end and the character writer.
// Uses iff_pkg for the descriptor type and the default depth.
module iff_queue import iff_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  output logic  full,
  input  logic  pop,
  output desc_t pop_desc,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          mem_r [DEPTH];
  logic [PW-1:0]  wr_r;
  logic [PW-1:0]  rd_r;
  logic [CW-1:0]  cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_desc = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/core/iff_back.sv
// Character writer: takes one descriptor from the queue and emits the field
// one character a cycle: left pad, prefix, zero pad, digits, right pad. Uses iff_pkg.
module iff_back import iff_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  desc_t             q_desc,
  output logic              q_pop,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  bstate_t           state_r, state_nxt;
  logic [DIG_W-1:0]  dw_r;
  logic [2:0]        dshift_r;
  logic              upper_r;
  logic [15:0]       pre_r;
  logic [1:0]        npre_r;
  logic [NDIG_W-1:0] ndig_r;
  logic [FW_W-1:0]   pad_r;
  pad_mode_e         mode_r;

  logic              valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  logic [CHAR_W-1:0] ch;
  logic              last;
  logic [3:0]        dig;
  logic              take_pad;
  logic              take_pre;
  logic              take_dig;

  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign dig   = digit_at(dw_r, dshift_r, ndig_r[DIDX_W-1:0] - DIDX_W'(1));
  assign last  = (pad_r + {5'd0, npre_r} + {1'b0, ndig_r}) == FW_W'(1);

  // Pick the next character in field order
  always_comb begin
    take_pad = 1'b0;
    take_pre = 1'b0;
    take_dig = 1'b0;
    ch       = CH_SPACE;
    if ((mode_r == PAD_LEFT) && (pad_r != '0)) begin
      take_pad = 1'b1;
    end else if (npre_r != 2'd0) begin
      take_pre = 1'b1;
      ch       = pre_r[15:8];
    end else if ((mode_r == PAD_ZERO) && (pad_r != '0)) begin
      take_pad = 1'b1;
      ch       = CH_ZERO;
    end else if (ndig_r != '0) begin
      take_dig = 1'b1;
      ch       = digit_char(dig, upper_r);
    end else begin
      take_pad = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_RUN;
      B_RUN:   if (last) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == B_RUN);
      last_r  <= (state_r == B_RUN) && last;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= ch;
    if (q_pop) begin
      dw_r     <= q_desc.dw;
      dshift_r <= q_desc.dshift;
      upper_r  <= q_desc.upper;
      pre_r    <= q_desc.pre;
      npre_r   <= q_desc.npre;
      ndig_r   <= q_desc.ndig;
      pad_r    <= q_desc.pad;
      mode_r   <= q_desc.mode;
    end else if (state_r == B_RUN) begin
      if (take_pad) begin
        pad_r <= pad_r - FW_W'(1);
      end
      if (take_pre) begin
        pre_r  <= {pre_r[7:0], 8'h00};
        npre_r <= npre_r - 2'd1;
      end
      if (take_dig) begin
        ndig_r <= ndig_r - NDIG_W'(1);
      end
    end
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

>>> rtl/core/integer_field_formatter.sv
// Integer field formatter: printf-style conversion of one integer into ASCII.
// A request is taken when start is high and busy is low. The front end then runs its
// one-bit-a-cycle binary-to-BCD converter for the decimal kinds (32-bit or 64-bit),
// skips it for the radix-2/8/16 kinds, then skips leading zero digits (up to 31 for
// binary) up to the first significant digit, and queues the result, holding while the
// queue is full; busy is high for all of that, so a new request is not taken until the
// previous one has been queued. The writer then emits the field one character a
// cycle on out_character, out_valid high for exactly one cycle per character and
// out_last on the final one, with a gap between fields. The output cannot be
// held off, so the receiver must take every character as it comes. A two-entry queue
// lets the next request convert while the previous field is still going out.
// Kind code 7 is taken and produces nothing. Depends on iff_pkg and the iff_* modules.
module integer_field_formatter import iff_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_kind,
  input  logic [63:0]       in_value,
  input  logic              in_wide,
  input  logic              in_left_justify,
  input  logic              in_zero_pad,
  input  logic              in_plus_sign,
  input  logic              in_space_sign,
  input  logic              in_alternate_form,
  input  logic [FW_W-1:0]   in_field_width,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  desc_t push_desc;
  desc_t pop_desc;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  iff_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .in_wide           (in_wide),
    .in_left_justify   (in_left_justify),
    .in_zero_pad       (in_zero_pad),
    .in_plus_sign      (in_plus_sign),
    .in_space_sign     (in_space_sign),
    .in_alternate_form (in_alternate_form),
    .in_field_width    (in_field_width),
    .q_push            (push),
    .q_desc            (push_desc),
    .q_full            (full)
  );

  iff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (empty)
  );

  iff_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (empty),
    .q_desc        (pop_desc),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

>>> rtl/core/iff_checker.sv
// Port-level checks for the integer field formatter, bound to the top level.
// Uses iff_pkg for the unused kind code, the character width and the space character.
module iff_checker import iff_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [2:0]        in_kind,
  input logic              out_valid,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last
);

  // A real request keeps the input closed while it converts
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_kind != KIND_NONE)) |=> busy)
    else $error("busy not raised after a request was taken");

  // Characters of one field come out back to back
  a_field_contig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a field");

  // Fields are kept apart: a last character is followed by a gap, not by the next field
  a_field_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("next field started straight after a last character");

  // Only printable characters from space up to lower-case z appear
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_character >= CH_SPACE) && (out_character <= 8'h7a)))
    else $error("character outside the expected set");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("activity straight after reset");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_kind       (in_kind),
  .out_valid     (out_valid),
  .out_character (out_character),
  .out_last      (out_last)
);
